### rtl/uni_pkg.sv
// Shared types and constants of the unicode transcoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package uni_pkg;

  // Conversion direction register codes
  typedef enum logic [2:0] {
    DIR_U8_U16  = 3'd0,
    DIR_U8_U32  = 3'd1,
    DIR_U16_U8  = 3'd2,
    DIR_U16_U32 = 3'd3,
    DIR_U32_U8  = 3'd4,
    DIR_U32_U16 = 3'd5
  } dir_t;

  // Target encoding of a decoded code point
  typedef enum logic [1:0] {
    DST_U8  = 2'd0,
    DST_U16 = 2'd1,
    DST_U32 = 2'd2
  } dst_t;

  localparam logic [20:0] CODE_MAX    = 21'h10FFFF;
  localparam logic [20:0] PLANE1_BASE = 21'h010000;

  // One input request
  typedef struct packed {
    logic [31:0] in_unit;
    logic        end_mark;
  } in_item_t;

  // One result request
  typedef struct packed {
    logic [20:0] out_unit;
    logic        has_unit;
    logic        run_last;
    logic        string_done;
    logic        failed;
  } out_item_t;

  // Work handed from the front to the back: one code point or one error
  typedef struct packed {
    logic [20:0] cp;
    dst_t        dst;
    logic        is_error;
    logic        last;
  } job_t;

endpackage

### rtl/uni_front.sv
// Front part of the unicode transcoder: accepts source units, collects
// UTF-8 sequences and surrogate pairs, checks them and issues jobs.
// Depends on uni_pkg.
module uni_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_data,
  input  logic             accept,
  input  uni_pkg::in_item_t item,
  output logic             job_valid,
  output uni_pkg::job_t    job
);

  uni_pkg::dir_t direction;
  logic [20:0]   partial_code, partial_code_next;
  logic [1:0]    bytes_left, bytes_left_next;
  logic [2:0]    seq_length, seq_length_next;
  logic [9:0]    high_half, high_half_next;
  logic          high_waiting, high_waiting_next;
  logic          error_seen, error_seen_next;

  logic          bad, have;
  logic [20:0]   cp;
  logic [20:0]   shifted;
  logic          first_cont;
  logic [7:0]    b;
  uni_pkg::dst_t dst;
  logic          src8, src16, src32;

  assign b = item.in_unit[7:0];
  assign shifted = {partial_code[14:0], b[5:0]};
  assign first_cont = (({1'b0, bytes_left} + 3'd1) == seq_length);

  // Decode source and target encodings from the direction
  always_comb begin
    src8  = 1'b0;
    src16 = 1'b0;
    src32 = 1'b0;
    dst   = uni_pkg::DST_U32;
    unique case (direction)
      uni_pkg::DIR_U8_U16:  begin src8  = 1'b1; dst = uni_pkg::DST_U16; end
      uni_pkg::DIR_U8_U32:  begin src8  = 1'b1; dst = uni_pkg::DST_U32; end
      uni_pkg::DIR_U16_U8:  begin src16 = 1'b1; dst = uni_pkg::DST_U8;  end
      uni_pkg::DIR_U16_U32: begin src16 = 1'b1; dst = uni_pkg::DST_U32; end
      uni_pkg::DIR_U32_U8:  begin src32 = 1'b1; dst = uni_pkg::DST_U8;  end
      uni_pkg::DIR_U32_U16: begin src32 = 1'b1; dst = uni_pkg::DST_U16; end
      default: ;
    endcase
  end

  // Classify the unit and compute the next collection state
  always_comb begin
    bad               = 1'b0;
    have              = 1'b0;
    cp                = '0;
    partial_code_next = partial_code;
    bytes_left_next   = bytes_left;
    seq_length_next   = seq_length;
    high_half_next    = high_half;
    high_waiting_next = high_waiting;
    error_seen_next   = error_seen;

    if (src8) begin
      if (item.in_unit[31:8] != 24'd0) begin
        bad = 1'b1;
      end else if (bytes_left == 2'd0) begin
        if (b < 8'h80) begin
          cp   = {14'd0, b[6:0]};
          have = 1'b1;
        end else if (b >= 8'hC2 && b < 8'hE0) begin
          partial_code_next = {16'd0, b[4:0]};
          bytes_left_next   = 2'd1;
          seq_length_next   = 3'd2;
        end else if (b >= 8'hE0 && b < 8'hF0) begin
          partial_code_next = {17'd0, b[3:0]};
          bytes_left_next   = 2'd2;
          seq_length_next   = 3'd3;
        end else if (b >= 8'hF0 && b < 8'hF8) begin
          partial_code_next = {18'd0, b[2:0]};
          bytes_left_next   = 2'd3;
          seq_length_next   = 3'd4;
        end else begin
          bad = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        bad = 1'b1;
      end else if (first_cont && partial_code == 21'd0 &&
                   ((seq_length == 3'd3 && !b[5]) ||
                    (seq_length == 3'd4 && b[5:4] == 2'b00))) begin
        // overlong three- or four-byte form
        bad = 1'b1;
      end else begin
        partial_code_next = shifted;
        bytes_left_next   = bytes_left - 2'd1;
        if (bytes_left == 2'd1) begin
          cp                = shifted;
          have              = 1'b1;
          partial_code_next = '0;
          seq_length_next   = '0;
          if (shifted > uni_pkg::CODE_MAX) bad = 1'b1;
        end
      end
    end else if (src16) begin
      if (item.in_unit[31:16] != 16'd0) begin
        bad = 1'b1;
      end else if (high_waiting) begin
        if (item.in_unit[15:10] == 6'b110111) begin
          cp = uni_pkg::PLANE1_BASE + {1'b0, high_half, 10'd0} +
               {11'd0, item.in_unit[9:0]};
          have              = 1'b1;
          high_waiting_next = 1'b0;
          high_half_next    = '0;
        end else begin
          bad = 1'b1;
        end
      end else if (item.in_unit[15:10] == 6'b110110) begin
        high_half_next    = item.in_unit[9:0];
        high_waiting_next = 1'b1;
      end else begin
        cp   = {5'd0, item.in_unit[15:0]};
        have = 1'b1;
      end
    end else if (src32) begin
      if (item.in_unit > {11'd0, uni_pkg::CODE_MAX}) begin
        bad = 1'b1;
      end else begin
        cp   = item.in_unit[20:0];
        have = 1'b1;
      end
    end else begin
      bad = 1'b1;
    end

    // a last unit that leaves a sequence open is an error
    if (!bad && item.end_mark && !have) bad = 1'b1;

    if (error_seen || bad || (have && item.end_mark)) begin
      partial_code_next = '0;
      bytes_left_next   = '0;
      seq_length_next   = '0;
      high_half_next    = '0;
      high_waiting_next = 1'b0;
      error_seen_next   = 1'b0;
    end
    if (error_seen && !item.end_mark) error_seen_next = 1'b1;
    if (!error_seen && bad && !item.end_mark) error_seen_next = 1'b1;
  end

  // Issue a job for each completed code point or fault; none while the rest of a faulty string is skipped
  assign job_valid    = accept && !error_seen && (bad || have);
  assign job.cp       = bad ? 21'd0 : cp;
  assign job.dst      = dst;
  assign job.is_error = bad;
  assign job.last     = item.end_mark;

  // Hold collection state; clear on direction write
  always_ff @(posedge clk) begin
    if (rst) begin
      direction    <= uni_pkg::DIR_U8_U16;
      partial_code <= '0;
      bytes_left   <= '0;
      seq_length   <= '0;
      high_half    <= '0;
      high_waiting <= 1'b0;
      error_seen   <= 1'b0;
    end else if (cfg_write) begin
      direction    <= uni_pkg::dir_t'(cfg_data);
      partial_code <= '0;
      bytes_left   <= '0;
      seq_length   <= '0;
      high_half    <= '0;
      high_waiting <= 1'b0;
      error_seen   <= 1'b0;
    end else if (accept) begin
      partial_code <= partial_code_next;
      bytes_left   <= bytes_left_next;
      seq_length   <= seq_length_next;
      high_half    <= high_half_next;
      high_waiting <= high_waiting_next;
      error_seen   <= error_seen_next;
    end
  end

endmodule

### rtl/uni_queue.sv
// Job queue between the front and back parts of the unicode transcoder.
// Register array with read and write pointers; depends on uni_pkg.
module uni_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  uni_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output uni_pkg::job_t pop_job,
  output logic          empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  uni_pkg::job_t     slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign pop_job = slots[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule

### rtl/uni_back.sv
// Back part of the unicode transcoder: expands each job into one to four
// target units, one per cycle while the result is not stalled, into the result register. Depends on uni_pkg.
module uni_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_ready,
  input  uni_pkg::job_t      job,
  output logic               job_pop,
  output logic               result_valid,
  input  logic               result_stall,
  output uni_pkg::out_item_t result_item
);

  logic [1:0]  unit_idx;
  logic [1:0]  last_idx;
  logic [20:0] unit;
  logic [19:0] offs;
  logic        load;
  logic        final_unit;

  assign offs = job.cp[19:0] - 20'h10000;

  // Count the target units of the job
  always_comb begin
    last_idx = 2'd0;
    if (!job.is_error) begin
      unique case (job.dst)
        uni_pkg::DST_U8: begin
          if (job.cp < 21'h80)         last_idx = 2'd0;
          else if (job.cp < 21'h800)   last_idx = 2'd1;
          else if (job.cp < 21'h10000) last_idx = 2'd2;
          else                         last_idx = 2'd3;
        end
        uni_pkg::DST_U16: last_idx = (job.cp < 21'h10000) ? 2'd0 : 2'd1;
        default:          last_idx = 2'd0;
      endcase
    end
  end

  // Form the unit at the current position
  always_comb begin
    unit = job.cp;
    if (job.is_error) begin
      unit = '0;
    end else begin
      unique case (job.dst)
        uni_pkg::DST_U8: begin
          case (last_idx)
            2'd1: unit = (unit_idx == 2'd0) ? {13'd0, 3'b110, job.cp[10:6]}
                                            : {13'd0, 2'b10, job.cp[5:0]};
            2'd2: begin
              case (unit_idx)
                2'd0:    unit = {13'd0, 4'b1110, job.cp[15:12]};
                2'd1:    unit = {13'd0, 2'b10, job.cp[11:6]};
                default: unit = {13'd0, 2'b10, job.cp[5:0]};
              endcase
            end
            2'd3: begin
              case (unit_idx)
                2'd0:    unit = {13'd0, 5'b11110, job.cp[20:18]};
                2'd1:    unit = {13'd0, 2'b10, job.cp[17:12]};
                2'd2:    unit = {13'd0, 2'b10, job.cp[11:6]};
                default: unit = {13'd0, 2'b10, job.cp[5:0]};
              endcase
            end
            default: unit = job.cp;
          endcase
        end
        uni_pkg::DST_U16: begin
          if (last_idx == 2'd1) begin
            unit = (unit_idx == 2'd0) ? {5'd0, 6'b110110, offs[19:10]}
                                      : {5'd0, 6'b110111, offs[9:0]};
          end
        end
        default: unit = job.cp;
      endcase
    end
  end

  assign load       = job_ready && (!result_valid || !result_stall);
  assign final_unit = (unit_idx == last_idx);
  assign job_pop    = load && final_unit;

  // Load the result register
  always_ff @(posedge clk) begin
    if (load) begin
      result_item.out_unit    <= unit;
      result_item.has_unit    <= !job.is_error;
      result_item.run_last    <= final_unit;
      result_item.string_done <= final_unit && job.last;
      result_item.failed      <= job.is_error;
    end
  end

  // Advance the unit position and the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      unit_idx     <= '0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
        unit_idx     <= final_unit ? 2'd0 : unit_idx + 2'd1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/unicode_transcoder.sv
// Unicode transcoder among UTF-8, UTF-16 and UTF-32, one source unit a request.
// Throughput: one source unit accepted per cycle while the job queue has room;
// the back part sends one target unit per cycle while result_stall is low and
// holds a code point until its last unit is sent. Jobs are registered in the queue,
// then in the result register. Reset (rst, synchronous) clears direction,
// collection state, queue and result valid flag at once; no clearing pass.
module unicode_transcoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_data,
  input  logic               unit_valid,
  output logic               unit_stall,
  input  uni_pkg::in_item_t  unit_item,
  output logic               result_valid,
  input  logic               result_stall,
  output uni_pkg::out_item_t result_item
);

  logic          accept;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  uni_pkg::job_t push_job;
  uni_pkg::job_t head_job;

  assign unit_stall = q_full;
  assign accept     = unit_valid && !unit_stall;

  uni_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (unit_item),
    .job_valid (q_push),
    .job       (push_job)
  );

  uni_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (head_job),
    .empty    (q_empty)
  );

  uni_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_ready    (!q_empty),
    .job          (head_job),
    .job_pop      (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  // Never push into a full queue
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("job pushed into full queue");

  // Never pop an empty queue
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("job popped from empty queue");

  // An error result carries no unit and closes its request
  assert property (@(posedge clk) disable iff (rst)
      (result_valid && result_item.failed) |->
      (!result_item.has_unit && result_item.run_last && result_item.out_unit == 21'd0))
    else $error("malformed error result");

  // String end only on the final result of a request
  assert property (@(posedge clk) disable iff (rst)
      (result_valid && result_item.string_done) |-> result_item.run_last)
    else $error("string_done without run_last");

endmodule
